>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Each macro clocks on the rising edge and is switched off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/lcdsp_pkg.sv
// Shared types, constants and filter functions of the subpixel FIR packer.
// No dependencies; lcdsp_apb_regs, lcdsp_filter and the top level import it.
package lcdsp_pkg;

    localparam logic [7:0] TAP_EDGE   = 8'h1C;
    localparam logic [7:0] TAP_NEAR   = 8'h38;
    localparam logic [7:0] TAP_CENTRE = 8'h55;
    localparam logic [7:0] MAX_BYTE   = 8'd255;

    // Position of a sample within its pixel.
    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_MID   = 2'd1;
    localparam logic [1:0] PHASE_THIRD = 2'd2;

    // Register indexes of the configuration port.
    localparam logic REG_BGR_ORDER = 1'b0;

    typedef struct packed {
        logic [3:0][7:0] hist;      // hist[0] is the newest sample
        logic [1:0]      line_pos;  // samples seen in the line, saturating at two
        logic [1:0]      phase;
        logic [1:0][7:0] pend;      // filtered first and middle subpixels
    } lcdsp_state_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] pixel;
        logic        last;
    } lcdsp_result_t;

    // Five-tap kernel, taps ordered from the newest sample to the oldest.
    function automatic logic [7:0] fir5(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d,
                                        input logic [7:0] e);
        logic [16:0] acc;
        acc = 17'(TAP_EDGE) * 17'(a) + 17'(TAP_NEAR) * 17'(b)
            + 17'(TAP_CENTRE) * 17'(c) + 17'(TAP_NEAR) * 17'(d)
            + 17'(TAP_EDGE) * 17'(e);
        if (acc[16:8] > 9'(MAX_BYTE))
            return MAX_BYTE;
        return acc[15:8];
    endfunction

    function automatic logic [31:0] pack_pixel(input logic [7:0] first,
                                               input logic [7:0] mid,
                                               input logic [7:0] third,
                                               input logic       bgr);
        logic [7:0] r;
        logic [7:0] b;
        r = bgr ? third : first;
        b = bgr ? first : third;
        return {mid, r, mid, b};
    endfunction

endpackage

>>> rtl/lcdsp_apb_regs.sv
// APB register file of the subpixel FIR packer: holds the subpixel order bit.
// Depends on lcdsp_pkg for the register indexes.
module lcdsp_apb_regs
    import lcdsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        bgr_order
);

    logic bgr_order_reg;
    logic bgr_order_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        bgr_order_next = bgr_order_reg;
        if (wr_en && (paddr[2] == REG_BGR_ORDER))
            bgr_order_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bgr_order_reg <= 1'b0;
        else
            bgr_order_reg <= bgr_order_next;
    end

    assign prdata    = (paddr[2] == REG_BGR_ORDER) ? {31'd0, bgr_order_reg} : 32'd0;
    assign bgr_order = bgr_order_reg;

endmodule

>>> rtl/lcdsp_filter.sv
// Combinational filter step: one sample against the line state gives the next
// state and at most one packed pixel. Depends on lcdsp_pkg.
module lcdsp_filter
    import lcdsp_pkg::*;
(
    input  lcdsp_state_t  st,
    input  logic [7:0]    sample,
    input  logic          line_end,
    input  logic          bgr_order,
    output lcdsp_state_t  st_next,
    output lcdsp_result_t res
);

    logic [1:0] phase;
    logic [7:0] y0;
    logic [7:0] y1;
    logic [7:0] y2;

    // A phase code of three cannot arise; it is handled as the first phase.
    assign phase = (st.phase == 2'd3) ? PHASE_FIRST : st.phase;

    assign y0 = fir5(sample, st.hist[0], st.hist[1], st.hist[2], st.hist[3]);
    assign y1 = fir5(8'd0, sample, st.hist[0], st.hist[1], st.hist[2]);
    assign y2 = fir5(8'd0, 8'd0, sample, st.hist[0], st.hist[1]);

    always_comb
    begin
        st_next = st;
        res     = '0;
        if (line_end && (phase == PHASE_THIRD))
        begin
            // The line ends on a whole pixel: flush the taps against zero.
            res.valid = 1'b1;
            res.pixel = pack_pixel(y0, y1, y2, bgr_order);
            res.last  = 1'b1;
            st_next   = '0;
        end
        else
        begin
            // The filtered value belongs to the subpixel two places back.
            if (st.line_pos >= 2'd2)
            begin
                unique case (phase)
                    PHASE_FIRST: st_next.pend[1] = y0;
                    PHASE_MID:
                    begin
                        res.valid = 1'b1;
                        res.pixel = pack_pixel(st.pend[0], st.pend[1], y0, bgr_order);
                    end
                    default:     st_next.pend[0] = y0;
                endcase
            end
            st_next.hist     = {st.hist[2:0], sample};
            st_next.line_pos = (st.line_pos >= 2'd2) ? st.line_pos : st.line_pos + 2'd1;
            st_next.phase    = (phase == PHASE_THIRD) ? PHASE_FIRST : phase + 2'd1;
        end
    end

endmodule

>>> rtl/lcd_subpixel_fir_argb_packer.sv
// Subpixel FIR and ARGB packer. A sample held in the input register is filtered
// when the output register is free or emptying; its pixel, if any, is then
// offered from that register. Throughput is one sample per cycle while m_tready
// holds, one pixel per three samples, set by the single input register and
// single result register around the filter step. Asynchronous active-low reset
// clears the line state, the valid flags and the subpixel order register (RGB).
module lcd_subpixel_fir_argb_packer
    import lcdsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] sample
    input  logic        s_tlast,    // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] argb_pixel
    output logic        m_tlast,    // pixel_line_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic          bgr_order;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [7:0]    s1_sample_reg;
    logic          s1_last_reg;
    lcdsp_state_t  st_reg;
    lcdsp_state_t  st_next;
    lcdsp_result_t res;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [31:0]   out_pixel_reg;
    logic          out_last_reg;
    logic          fire_in;
    logic          fire_proc;

    lcdsp_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .bgr_order (bgr_order)
    );

    lcdsp_filter u_filter (
        .st        (st_reg),
        .sample    (s1_sample_reg),
        .line_end  (s1_last_reg),
        .bgr_order (bgr_order),
        .st_next   (st_next),
        .res       (res)
    );

    // The held sample is processed when the output register is free or emptying.
    assign fire_proc = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || fire_proc;
    assign fire_in   = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (fire_in)
            s1_valid_next = 1'b1;
        else if (fire_proc)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire_proc)
            out_valid_next = res.valid;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire_proc)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_in)
        begin
            s1_sample_reg <= s_tdata;
            s1_last_reg   <= s_tlast;
        end
        if (fire_proc && res.valid)
        begin
            out_pixel_reg <= res.pixel;
            out_last_reg  <= res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/lcdsp_checker.sv
// Port-level checker of the subpixel FIR packer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lcdsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A stalled request stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // The alpha byte always repeats the green byte.
    `ASSERT_IMPLIES(a_alpha_green, clk, rst_n, m_tvalid, m_tdata[31:24] == m_tdata[15:8])
    // The kernel sums to 253, so no filtered byte exceeds 252.
    `ASSERT_IMPLIES(a_byte_range, clk, rst_n, m_tvalid, (m_tdata[23:16] <= 8'd252) && (m_tdata[7:0] <= 8'd252) && (m_tdata[15:8] <= 8'd252))
    // Input stalls only when a finished pixel is waiting on the output side.
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)

endmodule

bind lcd_subpixel_fir_argb_packer lcdsp_checker u_checker (.*);
